// ----- src/wrc_pkg.sv -----
`default_nettype none

package wrc_pkg;

	// tick space of the debounce arithmetic, the stamp port stays 32 bits
	localparam int TICK_WIDTH = 32;

	localparam int STAMP_W    = 32;
	localparam int CNT_W      = 32;
	localparam int TIME_W     = 16;
	localparam int MS_W       = 32;
	localparam int DEB_W      = 16;
	localparam int PER_W      = 10;
	localparam int BYTE_W     = 8;
	localparam int IDX_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int PKT_LEN = 7;
	localparam int PKT_W   = PKT_LEN * BYTE_W;
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(PKT_LEN - 1);
	localparam logic [BYTE_W-1:0] PKT_FLAGS = 8'h01;

	localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd1;
	localparam logic [PER_W-1:0] PERIOD_RST   = 10'd10;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// ms * 1024 / 1000 == ms * 128 / 125
	localparam int TIME_UNITS  = 1024;
	localparam int MS_PER_S    = 1000;
	localparam int SCALE_NUM   = TIME_UNITS / 8;
	localparam int DIV_MS      = MS_PER_S / 8;
	localparam int SCALE_SHIFT = $clog2(SCALE_NUM);
	localparam int RECIP_SHIFT = 38;
	localparam logic [MS_W-1:0] RECIP = MS_W'((64'd1 << RECIP_SHIFT) / DIV_MS);
	localparam int QEST_W = 2 * MS_W - RECIP_SHIFT;
	localparam int REM_W  = 8;
	localparam int FRAC_W = 8;

	typedef enum logic {
		OP_EDGE   = 1'b0,
		OP_NOTIFY = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE    = 2'd0,
		REG_TICK_PERIOD = 2'd1
	} reg_idx_t;

	typedef struct packed {
		op_t                   op;
		logic [TICK_WIDTH-1:0] tick;
		logic                  subscribed;
	} item_t;

	typedef struct packed {
		logic            valid;
		logic [MS_W-1:0] diff;
	} pipe_req_t;

	typedef struct packed {
		logic              busy;
		logic              inc_valid;
		logic [TIME_W-1:0] inc;
	} pipe_stat_t;

	// floor(r * 128 / 125) for r < 125, as r + floor(3r / 125)
	function automatic logic [FRAC_W-1:0] frac_scale(input logic [REM_W-1:0] r);
		logic [REM_W+1:0] r3;
		logic [FRAC_W-1:0] extra;
		r3 = (REM_W+2)'((SCALE_NUM - DIV_MS) * r);
		if (r3 >= (REM_W+2)'(2 * DIV_MS)) begin
			extra = FRAC_W'(2);
		end else if (r3 >= (REM_W+2)'(DIV_MS)) begin
			extra = FRAC_W'(1);
		end else begin
			extra = '0;
		end
		return FRAC_W'(r) + extra;
	endfunction

endpackage

`default_nettype wire

// ----- src/wrc_intf.sv -----
`default_nettype none

interface wrc_item_if;
	logic                       valid;
	logic                       ready;
	logic                       operation;
	logic [wrc_pkg::STAMP_W-1:0] event_tick;
	logic                       subscribed;

	modport source(output valid, operation, event_tick, subscribed, input ready);
	modport sink(input valid, operation, event_tick, subscribed, output ready);
endinterface

interface wrc_result_if;
	logic                       valid;
	logic                       ready;
	logic [wrc_pkg::BYTE_W-1:0] packet_byte;
	logic [wrc_pkg::IDX_W-1:0]  byte_index;
	logic                       last_byte;

	modport source(output valid, packet_byte, byte_index, last_byte, input ready);
	modport sink(input valid, packet_byte, byte_index, last_byte, output ready);
endinterface

interface wrc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [wrc_pkg::CFG_IDX_W-1:0]  index;
	logic [wrc_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/wheel_revolution_csc_reporter.sv -----
// a notify request passes the request queue, then loads the packet register and raises
// the result valid; it waits while interval conversions of earlier edges are in flight
// throughput: one request per cycle if no notify waits; a packet holds the byte serializer
// the interval conversion is a four-stage pipeline (multiply, reciprocal, remainder, scale)
// reset: asynchronous, active low; counts and times clear, debounce 1, tick period 10 ms
`default_nettype none

module wheel_revolution_csc_reporter (
	input  wire logic    clk,
	input  wire logic    arst_n,
	wrc_item_if.sink     item,
	wrc_result_if.source result,
	wrc_cfg_if.sink      cfg
);

	logic [wrc_pkg::DEB_W-1:0] debounce_q;
	logic [wrc_pkg::PER_W-1:0] period_q;
	wrc_pkg::item_t            head;
	logic                      head_valid;
	logic                      q_pop;
	wrc_pkg::pipe_req_t        pipe_req;
	wrc_pkg::pipe_stat_t       pstat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= wrc_pkg::DEBOUNCE_RST;
			period_q   <= wrc_pkg::PERIOD_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				wrc_pkg::REG_DEBOUNCE: begin
					debounce_q <= cfg.data[wrc_pkg::DEB_W-1:0];
				end
				wrc_pkg::REG_TICK_PERIOD: begin
					period_q <= cfg.data[wrc_pkg::PER_W-1:0];
				end
				default: begin
					debounce_q <= debounce_q;
				end
			endcase
		end
	end

	wrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.head       (head),
		.head_valid (head_valid),
		.pop        (q_pop)
	);

	wrc_edge_pipe u_edge_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.period (period_q),
		.req    (pipe_req),
		.stat   (pstat)
	);

	wrc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.debounce   (debounce_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (q_pop),
		.req        (pipe_req),
		.stat       (pstat),
		.result     (result)
	);

	a_inc_follows_edge: assert property (@(posedge clk) disable iff (!arst_n)
		pstat.inc_valid |-> $past(pipe_req.valid, 4))
		else $error("interval increment without a matching edge");

	a_notify_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && head.op == wrc_pkg::OP_NOTIFY) |-> !pstat.busy)
		else $error("notify issued with intervals in flight");

	a_req_from_edge: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_req.valid |-> (q_pop && head_valid && head.op == wrc_pkg::OP_EDGE))
		else $error("conversion started without an edge pop");

	a_packet_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && result.last_byte)
			|=> (!result.valid || result.byte_index == '0))
		else $error("packet does not restart at the first byte");

endmodule

`default_nettype wire

// ----- src/wrc_front.sv -----
`default_nettype none

module wrc_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	wrc_item_if.sink          item,
	output wrc_pkg::item_t    head,
	output logic              head_valid,
	input  wire logic         pop
);

	wrc_pkg::item_t mem_q [wrc_pkg::QUEUE_DEPTH];
	logic [wrc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [wrc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [wrc_pkg::QPTR_W:0]   count_q;
	wrc_pkg::item_t             incoming;
	logic                       push;
	logic                       do_pop;

	assign item.ready = (count_q != (wrc_pkg::QPTR_W+1)'(wrc_pkg::QUEUE_DEPTH));
	assign push       = item.valid && item.ready;
	assign head_valid = (count_q != '0);
	assign do_pop     = pop && head_valid;
	assign head       = mem_q[rd_ptr_q];

	// classify the request and bring the stamp into tick space
	always_comb begin
		incoming.op         = item.operation ? wrc_pkg::OP_NOTIFY : wrc_pkg::OP_EDGE;
		incoming.tick       = wrc_pkg::TICK_WIDTH'(item.event_tick);
		incoming.subscribed = item.subscribed;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/wrc_edge_pipe.sv -----
`default_nettype none

module wrc_edge_pipe (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [wrc_pkg::PER_W-1:0]  period,
	input  wire wrc_pkg::pipe_req_t         req,
	output wrc_pkg::pipe_stat_t             stat
);

	logic                        v_s1, v_s2, v_s3, v_s4;
	logic [wrc_pkg::MS_W-1:0]    ms_s1;
	logic [wrc_pkg::REM_W-1:0]   ms_lo_s2;
	logic [wrc_pkg::QEST_W-1:0]  q_s2, q_s3;
	logic [wrc_pkg::REM_W-1:0]   r_s3;
	logic [wrc_pkg::TIME_W-1:0]  inc_s4;
	logic [2*wrc_pkg::MS_W-1:0]  prod;
	logic [wrc_pkg::REM_W-1:0]   r_raw;
	logic [wrc_pkg::QEST_W-1:0]  q_fix;
	logic [wrc_pkg::REM_W-1:0]   r_fix;
	logic [wrc_pkg::TIME_W-1:0]  inc;

	// quotient estimate by reciprocal, low by at most one
	assign prod  = ms_s1 * wrc_pkg::RECIP;
	// remainder is below 250, so its low byte is exact
	assign r_raw = wrc_pkg::REM_W'(ms_lo_s2 - wrc_pkg::REM_W'(q_s2 * wrc_pkg::DIV_MS));

	always_comb begin
		if (r_s3 >= wrc_pkg::REM_W'(wrc_pkg::DIV_MS)) begin
			q_fix = q_s3 + 1'b1;
			r_fix = r_s3 - wrc_pkg::REM_W'(wrc_pkg::DIV_MS);
		end else begin
			q_fix = q_s3;
			r_fix = r_s3;
		end
		inc = wrc_pkg::TIME_W'({q_fix, {wrc_pkg::SCALE_SHIFT{1'b0}}})
			+ wrc_pkg::TIME_W'(wrc_pkg::frac_scale(r_fix));
	end

	always_ff @(posedge clk) begin
		ms_s1    <= wrc_pkg::MS_W'(req.diff * period);
		ms_lo_s2 <= ms_s1[wrc_pkg::REM_W-1:0];
		q_s2     <= prod[2*wrc_pkg::MS_W-1:wrc_pkg::RECIP_SHIFT];
		q_s3     <= q_s2;
		r_s3     <= r_raw;
		inc_s4   <= inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign stat.busy      = v_s1 || v_s2 || v_s3 || v_s4;
	assign stat.inc_valid = v_s4;
	assign stat.inc       = inc_s4;

endmodule

`default_nettype wire

// ----- src/wrc_back.sv -----
`default_nettype none

module wrc_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [wrc_pkg::DEB_W-1:0]  debounce,
	input  wire wrc_pkg::item_t             head,
	input  wire logic                       head_valid,
	output logic                            pop,
	output wrc_pkg::pipe_req_t              req,
	input  wire wrc_pkg::pipe_stat_t        stat,
	wrc_result_if.source                    result
);

	logic [wrc_pkg::TICK_WIDTH-1:0] last_edge_q;
	logic [wrc_pkg::CNT_W-1:0]      rev_q;
	logic [wrc_pkg::TIME_W-1:0]     time_q;
	logic [wrc_pkg::CNT_W-1:0]      sent_q;
	logic                           busy_q;
	logic [wrc_pkg::IDX_W-1:0]      idx_q;
	logic [wrc_pkg::PKT_W-1:0]      pkt_q;

	logic [wrc_pkg::TICK_WIDTH-1:0] diff;
	logic                           accept;
	logic                           changed;
	logic                           emit;
	logic                           ser_free;
	logic                           edge_go;
	logic                           notify_go;
	logic                           last_taken;

	assign diff       = head.tick - last_edge_q;
	assign accept     = diff > wrc_pkg::TICK_WIDTH'(debounce);
	assign changed    = (rev_q != sent_q);
	assign emit       = changed && head.subscribed;
	assign last_taken = busy_q && result.ready && (idx_q == wrc_pkg::LAST_IDX);
	assign ser_free   = !busy_q || last_taken;

	// notify waits on intervals in flight and, when sending, the serializer
	always_comb begin
		edge_go   = 1'b0;
		notify_go = 1'b0;
		if (head_valid) begin
			case (head.op)
				wrc_pkg::OP_EDGE: begin
					edge_go = 1'b1;
				end
				wrc_pkg::OP_NOTIFY: begin
					notify_go = !stat.busy && (!emit || ser_free);
				end
				default: begin
					edge_go = 1'b0;
				end
			endcase
		end
	end

	assign pop       = edge_go || notify_go;
	assign req.valid = edge_go && accept;
	assign req.diff  = wrc_pkg::MS_W'(diff);

	always_ff @(posedge clk) begin
		if (notify_go && emit) begin
			pkt_q <= {time_q, rev_q, wrc_pkg::PKT_FLAGS};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
			rev_q       <= '0;
			time_q      <= '0;
			sent_q      <= '0;
			busy_q      <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (edge_go && accept) begin
				last_edge_q <= head.tick;
				rev_q       <= rev_q + 1'b1;
			end
			if (stat.inc_valid) begin
				time_q <= time_q + stat.inc;
			end
			if (notify_go && changed && !head.subscribed) begin
				rev_q  <= '0;
				time_q <= '0;
			end
			if (notify_go && emit) begin
				sent_q <= rev_q;
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (last_taken) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else if (busy_q && result.ready) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign result.valid       = busy_q;
	assign result.byte_index  = idx_q;
	assign result.last_byte   = (idx_q == wrc_pkg::LAST_IDX);
	assign result.packet_byte = pkt_q[idx_q*wrc_pkg::BYTE_W +: wrc_pkg::BYTE_W];

endmodule

`default_nettype wire

// ----- tb/wheel_revolution_csc_reporter_tb.sv -----
`timescale 1ns / 1ps

module wheel_revolution_csc_reporter_tb;

	localparam int FROM_MODEL     = -1;
	localparam int NO_BYTES       = 0;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int NUM_PHASES     = 6;
	localparam int PHASE_ITEMS    = 17;
	localparam int NUM_DIRECTED   = 20;

	typedef struct {
		logic [wrc_pkg::BYTE_W-1:0] value;
		logic [wrc_pkg::IDX_W-1:0]  index;
		logic                       last;
	} pkt_byte_t;

	typedef struct {
		wrc_pkg::op_t                op;
		logic [wrc_pkg::STAMP_W-1:0] tick;
		logic                        sub;
		int                          want_n;
		logic [wrc_pkg::PKT_W-1:0]   want_pkt;
	} directed_row_t;

	logic clk;
	logic arst_n;

	wrc_item_if   item_ch();
	wrc_result_if result_ch();
	wrc_cfg_if    cfg_ch();

	wheel_revolution_csc_reporter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// wheel state as the block should hold it
	logic [wrc_pkg::DEB_W-1:0]      cfg_debounce = wrc_pkg::DEBOUNCE_RST;
	logic [wrc_pkg::PER_W-1:0]      cfg_period_ms = wrc_pkg::PERIOD_RST;
	logic [wrc_pkg::TICK_WIDTH-1:0] wheel_last_edge = '0;
	logic [wrc_pkg::CNT_W-1:0]      wheel_revs = '0;
	logic [wrc_pkg::TIME_W-1:0]     wheel_time = '0;
	logic [wrc_pkg::CNT_W-1:0]      wheel_sent = '0;

	pkt_byte_t pending_bytes[$];
	pkt_byte_t popped;
	int        mismatches = 0;
	int        quiet_cycles = 0;
	int        burst_left = 0;

	// packet bytes listed from byte 0 at the top
	directed_row_t directed_rows [NUM_DIRECTED] = '{
		'{wrc_pkg::OP_NOTIFY, 32'h0,        1'b1, NO_BYTES,   '0},
		'{wrc_pkg::OP_EDGE,   32'h1,        1'b0, FROM_MODEL, '0},
		'{wrc_pkg::OP_EDGE,   32'd100,      1'b0, FROM_MODEL, '0},
		'{wrc_pkg::OP_EDGE,   32'd100,      1'b1, FROM_MODEL, '0},
		'{wrc_pkg::OP_NOTIFY, 32'h0,        1'b1, wrc_pkg::PKT_LEN, 56'h01_01_00_00_00_00_04},
		'{wrc_pkg::OP_NOTIFY, 32'h0,        1'b1, NO_BYTES,   '0},
		'{wrc_pkg::OP_EDGE,   32'hFFFFFFFF, 1'b0, FROM_MODEL, '0},
		'{wrc_pkg::OP_EDGE,   32'h5,        1'b0, FROM_MODEL, '0},
		'{wrc_pkg::OP_NOTIFY, 32'h0,        1'b0, NO_BYTES,   '0},
		'{wrc_pkg::OP_NOTIFY, 32'h0,        1'b1, wrc_pkg::PKT_LEN, 56'h01_00_00_00_00_00_00},
		'{wrc_pkg::OP_NOTIFY, 32'hFFFFFFFF, 1'b0, NO_BYTES,   '0},
		'{wrc_pkg::OP_EDGE,   32'hAAAAAAAA, 1'b0, FROM_MODEL, '0},
		'{wrc_pkg::OP_EDGE,   32'hAAAAAAAB, 1'b1, FROM_MODEL, '0},
		'{wrc_pkg::OP_EDGE,   32'hAAAAAAAC, 1'b0, FROM_MODEL, '0},
		'{wrc_pkg::OP_EDGE,   32'h55555555, 1'b0, FROM_MODEL, '0},
		'{wrc_pkg::OP_NOTIFY, 32'h12345678, 1'b1, FROM_MODEL, '0},
		'{wrc_pkg::OP_EDGE,   32'h55555557, 1'b0, FROM_MODEL, '0},
		'{wrc_pkg::OP_NOTIFY, 32'h0,        1'b1, FROM_MODEL, '0},
		'{wrc_pkg::OP_EDGE,   32'h0,        1'b0, FROM_MODEL, '0},
		'{wrc_pkg::OP_NOTIFY, 32'hFFFFFFFF, 1'b0, FROM_MODEL, '0}
	};

	logic [wrc_pkg::DEB_W-1:0]      phase_debounce [NUM_PHASES] = '{16'd0, 16'hFFFF, 16'd0,
		16'd300, 16'd0, 16'd1};
	logic [wrc_pkg::CFG_DATA_W-1:0] phase_period [NUM_PHASES] = '{16'd1, 16'd1000, 16'd0,
		16'd1023, 16'd0, 16'd10};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void wheel_step(input wrc_pkg::op_t op,
		input logic [wrc_pkg::STAMP_W-1:0] tick, input logic sub, output int n,
		output logic [wrc_pkg::PKT_W-1:0] pkt);
		logic [wrc_pkg::TICK_WIDTH-1:0] diff;
		logic [63:0] prod;
		logic [63:0] scaled;
		n = 0;
		pkt = '0;
		if (op == wrc_pkg::OP_EDGE) begin
			diff = wrc_pkg::TICK_WIDTH'(tick) - wheel_last_edge;
			if (diff > wrc_pkg::TICK_WIDTH'(cfg_debounce)) begin
				prod = 64'(diff) * 64'(cfg_period_ms);
				scaled = (64'(prod[wrc_pkg::MS_W-1:0]) * 64'd1024) / 64'd1000;
				wheel_last_edge = wrc_pkg::TICK_WIDTH'(tick);
				wheel_revs = wheel_revs + 1'b1;
				wheel_time = wheel_time + scaled[wrc_pkg::TIME_W-1:0];
			end
		end else if (wheel_revs != wheel_sent) begin
			if (!sub) begin
				wheel_revs = '0;
				wheel_time = '0;
			end else begin
				wheel_sent = wheel_revs;
				pkt = {wrc_pkg::PKT_FLAGS, wheel_revs[7:0], wheel_revs[15:8],
					wheel_revs[23:16], wheel_revs[31:24], wheel_time[7:0], wheel_time[15:8]};
				n = wrc_pkg::PKT_LEN;
			end
		end
	endfunction

	function automatic void queue_packet(input int n, input logic [wrc_pkg::PKT_W-1:0] pkt);
		pkt_byte_t b;
		for (int k = 0; k < n; k++) begin
			b.value = pkt[wrc_pkg::PKT_W-1-wrc_pkg::BYTE_W*k -: wrc_pkg::BYTE_W];
			b.index = wrc_pkg::IDX_W'(k);
			b.last = (b.index == wrc_pkg::LAST_IDX);
			pending_bytes.push_back(b);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// valid stays high on return, the caller decides on the gap
	task automatic send_request(input wrc_pkg::op_t op, input logic [wrc_pkg::STAMP_W-1:0] tick,
		input logic sub, input int want_n, input logic [wrc_pkg::PKT_W-1:0] want_pkt);
		int n;
		logic [wrc_pkg::PKT_W-1:0] pkt;
		item_ch.valid <= 1'b1;
		item_ch.operation <= op;
		item_ch.event_tick <= tick;
		item_ch.subscribed <= sub;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		wheel_step(op, tick, sub, n, pkt);
		if (want_n == FROM_MODEL) begin
			queue_packet(n, pkt);
		end else begin
			queue_packet(want_n, want_pkt);
		end
	endtask

	// always waits on the clock before returning, so valid is never lowered and raised in one step
	task automatic wait_drained(input int extra);
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_bytes.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if ($urandom_range(0, 19) == 0) begin
				wait_drained(0);
			end else if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic program_regs(input logic [wrc_pkg::DEB_W-1:0] deb,
		input logic [wrc_pkg::CFG_DATA_W-1:0] per);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= wrc_pkg::REG_DEBOUNCE;
		cfg_ch.data <= wrc_pkg::CFG_DATA_W'(deb);
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_debounce = deb;
		cfg_ch.index <= wrc_pkg::REG_TICK_PERIOD;
		cfg_ch.data <= per;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_period_ms = per[wrc_pkg::PER_W-1:0];
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_random_request();
		wrc_pkg::op_t op;
		logic [wrc_pkg::STAMP_W-1:0] tick;
		logic sub;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			op = wrc_pkg::OP_NOTIFY;
			tick = $urandom;
			sub = ($urandom_range(0, 9) != 0);
		end else begin
			op = wrc_pkg::OP_EDGE;
			sub = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				tick = wrc_pkg::STAMP_W'(wheel_last_edge + cfg_debounce
					+ $urandom_range(1, 3000));
			end else if (pick < 80) begin
				// bounce inside the debounce window, the window edge included
				tick = wrc_pkg::STAMP_W'(wheel_last_edge + $urandom_range(0, cfg_debounce));
			end else if (pick < 90) begin
				tick = wrc_pkg::STAMP_W'(wheel_last_edge + cfg_debounce + 1);
			end else begin
				tick = $urandom;
			end
		end
		send_request(op, tick, sub, FROM_MODEL, '0);
	endtask

	// receiver stalls in modes of random length
	initial begin
		int mode;
		int mode_left;
		int unsigned cyc;
		mode = 0;
		mode_left = 0;
		cyc = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(10, 60);
			end else begin
				mode_left--;
			end
			case (mode)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= 1'($urandom_range(0, 1));
				2: result_ch.ready <= ($urandom_range(0, 3) == 0);
				default: result_ch.ready <= cyc[2];
			endcase
		end
	end

	always @(posedge clk) begin
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch("unexpected byte", 32'(result_ch.packet_byte), 32'd0);
			end else begin
				popped = pending_bytes.pop_front();
				if (result_ch.packet_byte !== popped.value)
					report_mismatch("packet_byte", 32'(result_ch.packet_byte),
						32'(popped.value));
				if (result_ch.byte_index !== popped.index)
					report_mismatch("byte_index", 32'(result_ch.byte_index),
						32'(popped.index));
				if (result_ch.last_byte !== popped.last)
					report_mismatch("last_byte", 32'(result_ch.last_byte),
						32'(popped.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
			(result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
			(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.operation = wrc_pkg::OP_EDGE;
		item_ch.event_tick = '0;
		item_ch.subscribed = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = wrc_pkg::REG_DEBOUNCE;
		cfg_ch.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part runs under the reset settings
		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].op, directed_rows[i].tick, directed_rows[i].sub,
				directed_rows[i].want_n, directed_rows[i].want_pkt);
			pace_sender();
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained(SETTLE_CYCLES);
			if (p == 4) begin
				// upper data bits of the period write fall outside the register
				program_regs(wrc_pkg::DEB_W'($urandom_range(0, 65535)),
					wrc_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
			end else begin
				program_regs(phase_debounce[p], phase_period[p]);
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_random_request();
				pace_sender();
			end
		end

		wait_drained(SETTLE_CYCLES);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/wrc_pkg.sv
src/wrc_intf.sv
src/wrc_front.sv
src/wrc_edge_pipe.sv
src/wrc_back.sv
src/wheel_revolution_csc_reporter.sv
tb/wheel_revolution_csc_reporter_tb.sv
